// File: rtl/cleb_pkg.sv
// Shared definitions for the cursor line edit buffer: default depth,
// command codes and sequencer states. No dependencies.
`timescale 1ns / 1ps

package cleb_pkg;

    // Default number of character positions in the line.
    localparam int LEN_DEFAULT = 64;

    typedef enum logic [2:0]
    {
        CMD_INSERT    = 3'd0,
        CMD_MOVE      = 3'd1,
        CMD_BACKSPACE = 3'd2,
        CMD_DELETE    = 3'd3,
        CMD_PRINT     = 3'd4
    } cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_SHR_RD,
        ST_SHR_WR,
        ST_PUT,
        ST_SHL_RD,
        ST_SHL_WR,
        ST_PR_RD,
        ST_PR_OUT
    } state_t;

endpackage

// File: rtl/cursor_line_edit_buffer.sv
// Cursor line edit buffer: character store, length, cursor and the
// sequencer that edits and prints the line. Depends on cleb_pkg.
`timescale 1ns / 1ps

// How the block is used.
// An item (command, char_in, offset) is taken at a rising edge at which
// start is high and busy is low; busy then stays high until the command
// has finished, and no further item is taken meanwhile.
// Only print gives results: one char_out per stored character, in order
// from the start of the line, each on the ports for exactly one cycle
// while result_strobe is high, with last_char set on the final one. An
// empty line prints nothing. The receiver cannot stall, so results are
// simply presented once and never held.
// Every command passes through the execute state. Move, ignored edits
// and unused codes then return to idle. Insert first moves the tail
// right, a read state and a write state per character from the cursor
// on, and then writes the new character in the put state. Backspace and
// delete move each character after the removed one left, again by a read
// state and a write state. Print takes a read state and an output state
// per character. The character memory has one write and one read port,
// and all index steps and the cursor move go through one shared adder.
// Reset clears length, cursor and the sequencer; the character memory is
// not cleared, since only written positions are read.
module cursor_line_edit_buffer
#(
    parameter int LEN = cleb_pkg::LEN_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        command,
    input  logic [7:0]        char_in,
    input  logic signed [7:0] offset,
    output logic              result_strobe,
    output logic [7:0]        char_out,
    output logic              last_char
);

    // Position width holds 0..LEN, address width indexes 0..LEN-1.
    localparam int PW = $clog2(LEN + 1);
    localparam int AW = (LEN > 1) ? $clog2(LEN) : 1;
    // The shared adder is wide enough for cursor plus a signed byte.
    localparam int SW = ((PW + 1 > 8) ? PW + 1 : 8) + 1;

    cleb_pkg::state_t state_reg, state_next;

    logic [2:0]        cmd_reg,    cmd_next;
    logic [7:0]        char_reg,   char_next;
    logic signed [7:0] offset_reg, offset_next;
    logic [PW-1:0]     len_reg,    len_next;
    logic [PW-1:0]     cursor_reg, cursor_next;
    logic [PW-1:0]     k_reg,      k_next;
    logic [AW-1:0]     wa_reg,     wa_next;

    // Character memory with one write and one registered read per cycle.
    logic [7:0]    mem [LEN];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    // Shared adder used for every index step and for the cursor move.
    logic signed [SW-1:0] alu_a, alu_b, alu_sum;
    logic signed [SW-1:0] len_ext;

    assign alu_sum = alu_a + alu_b;
    assign len_ext = signed'({{(SW - PW){1'b0}}, len_reg});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cleb_pkg::ST_IDLE;
            len_reg    <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        char_reg   <= char_next;
        offset_reg <= offset_next;
        k_reg      <= k_next;
        wa_reg     <= wa_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        char_next     = char_reg;
        offset_next   = offset_reg;
        len_next      = len_reg;
        cursor_next   = cursor_reg;
        k_next        = k_reg;
        wa_next       = wa_reg;
        rd_addr       = k_reg[AW-1:0];
        mem_we        = 1'b0;
        mem_wa        = wa_reg;
        mem_wd        = rd_data_reg;
        alu_a         = signed'({{(SW - PW){1'b0}}, k_reg});
        alu_b         = signed'({{(SW - 1){1'b0}}, 1'b1});
        busy          = (state_reg != cleb_pkg::ST_IDLE);
        result_strobe = 1'b0;
        char_out      = rd_data_reg;
        last_char     = 1'b0;

        unique case (state_reg)
            cleb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command;
                    char_next   = char_in;
                    offset_next = offset;
                    state_next  = cleb_pkg::ST_EXEC;
                end
            end

            cleb_pkg::ST_EXEC:
            begin
                alu_a      = signed'({{(SW - PW){1'b0}}, cursor_reg});
                state_next = cleb_pkg::ST_IDLE;
                unique case (cmd_reg)
                    cleb_pkg::CMD_INSERT:
                    begin
                        // A full line ignores the insert.
                        if (len_reg < PW'(LEN))
                        begin
                            k_next = len_reg;
                            if (len_reg > cursor_reg)
                            begin
                                state_next = cleb_pkg::ST_SHR_RD;
                            end
                            else
                            begin
                                state_next = cleb_pkg::ST_PUT;
                            end
                        end
                    end
                    cleb_pkg::CMD_MOVE:
                    begin
                        alu_b = signed'({{(SW - 8){offset_reg[7]}}, offset_reg});
                        if (alu_sum > len_ext)
                        begin
                            cursor_next = len_reg;
                        end
                        else if (alu_sum < 0)
                        begin
                            cursor_next = '0;
                        end
                        else
                        begin
                            cursor_next = alu_sum[PW-1:0];
                        end
                    end
                    cleb_pkg::CMD_BACKSPACE:
                    begin
                        alu_b = signed'({SW{1'b1}});
                        if (cursor_reg != '0)
                        begin
                            k_next      = alu_sum[PW-1:0];
                            cursor_next = alu_sum[PW-1:0];
                            state_next  = cleb_pkg::ST_SHL_RD;
                        end
                    end
                    cleb_pkg::CMD_DELETE:
                    begin
                        if (cursor_reg < len_reg)
                        begin
                            k_next     = cursor_reg;
                            state_next = cleb_pkg::ST_SHL_RD;
                        end
                    end
                    cleb_pkg::CMD_PRINT:
                    begin
                        k_next = '0;
                        if (len_reg != '0)
                        begin
                            state_next = cleb_pkg::ST_PR_RD;
                        end
                    end
                    default:
                    begin
                        state_next = cleb_pkg::ST_IDLE;
                    end
                endcase
            end

            // Open a gap at the cursor, moving the tail right one place,
            // from the end downwards.
            cleb_pkg::ST_SHR_RD:
            begin
                alu_b      = signed'({SW{1'b1}});
                rd_addr    = alu_sum[AW-1:0];
                wa_next    = k_reg[AW-1:0];
                k_next     = alu_sum[PW-1:0];
                state_next = cleb_pkg::ST_SHR_WR;
            end

            cleb_pkg::ST_SHR_WR:
            begin
                mem_we = 1'b1;
                if (k_reg > cursor_reg)
                begin
                    state_next = cleb_pkg::ST_SHR_RD;
                end
                else
                begin
                    state_next = cleb_pkg::ST_PUT;
                end
            end

            cleb_pkg::ST_PUT:
            begin
                mem_we      = 1'b1;
                mem_wa      = cursor_reg[AW-1:0];
                mem_wd      = char_reg;
                len_next    = len_reg + PW'(1);
                cursor_next = cursor_reg + PW'(1);
                state_next  = cleb_pkg::ST_IDLE;
            end

            // Close the gap at k, moving the tail left one place.
            cleb_pkg::ST_SHL_RD:
            begin
                if (alu_sum[PW-1:0] < len_reg)
                begin
                    rd_addr    = alu_sum[AW-1:0];
                    wa_next    = k_reg[AW-1:0];
                    k_next     = alu_sum[PW-1:0];
                    state_next = cleb_pkg::ST_SHL_WR;
                end
                else
                begin
                    len_next   = len_reg - PW'(1);
                    state_next = cleb_pkg::ST_IDLE;
                end
            end

            cleb_pkg::ST_SHL_WR:
            begin
                mem_we     = 1'b1;
                state_next = cleb_pkg::ST_SHL_RD;
            end

            cleb_pkg::ST_PR_RD:
            begin
                state_next = cleb_pkg::ST_PR_OUT;
            end

            cleb_pkg::ST_PR_OUT:
            begin
                result_strobe = 1'b1;
                last_char     = (alu_sum[PW-1:0] == len_reg);
                k_next        = alu_sum[PW-1:0];
                if (last_char)
                begin
                    state_next = cleb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cleb_pkg::ST_PR_RD;
                end
            end

            default:
            begin
                state_next = cleb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
